// ----- sv/ibmva_pkg.sv -----
// ----------------------------------------------------------------------------
// ibmva_pkg
// Shared types and constants of the indexed block matrix-vector accumulator.
// ----------------------------------------------------------------------------
package ibmva_pkg;

  localparam int unsigned MAX_ROWS = 16;
  localparam int unsigned ROW_W    = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned OPD_W    = 32;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [OPD_W-1:0] matrix_value;
    logic signed [OPD_W-1:0] vector_value;
    logic [ROW_W-1:0]        row_position;
    logic                    has_product;
    logic                    end_of_column;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] sum;
    logic                    saturated;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic add;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- sv/ibmva_cell.sv -----
// ----------------------------------------------------------------------------
// ibmva_cell
// One row cell: saturating Q32.32 accumulator with sticky mark; shifts its
// contents to the neighbor toward the output during a column drain.
// ----------------------------------------------------------------------------
module ibmva_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ibmva_pkg::cell_ctrl_t      ctrl_i,
  input  logic [ibmva_pkg::ACC_W-1:0] prod_i,
  input  logic [ibmva_pkg::ACC_W-1:0] nbr_acc_i,
  input  logic                       nbr_sat_i,
  output logic [ibmva_pkg::ACC_W-1:0] acc_o,
  output logic                       sat_o
);
  import ibmva_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic             sat_q, sat_d;
  logic [ACC_W-1:0] sum;
  logic             ovf;

  assign sum = acc_q + prod_i;
  assign ovf = (acc_q[ACC_W-1] == prod_i[ACC_W-1]) && (sum[ACC_W-1] != acc_q[ACC_W-1]);

  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      sat_d = 1'b0;
    end else if (ctrl_i.shift) begin
      acc_d = nbr_acc_i;
      sat_d = nbr_sat_i;
    end else if (ctrl_i.add) begin
      if (ovf) begin
        acc_d = prod_i[ACC_W-1] ? ACC_MIN : ACC_MAX;
        sat_d = 1'b1;
      end else begin
        acc_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

// ----- sv/indexed_block_matvec_accumulate.sv -----
// ----------------------------------------------------------------------------
// indexed_block_matvec_accumulate
// Multiply-accumulate core of a batched, index-gathered matrix-vector product.
// ----------------------------------------------------------------------------
// Each transaction multiplies two Q16.16 operands into an exact Q32.32
// product (one registered 32x32 multiply) and adds it, saturating, into the
// row cell that row_position selects; rows at or above the active row count
// (rows_per_output clamped to 1..16) are dropped. An item is multiplied into
// the product register, then accumulated in the cell chain, with the input
// stalled meanwhile. An end_of_column item then drains the chain toward the
// output register, one row per cycle while the output side does not stall,
// holding the input until done; then all cells and marks clear. The user
// must write rows_per_output only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module indexed_block_matvec_accumulate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ibmva_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ibmva_pkg::out_item_t           out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ibmva_pkg::CNT_W-1:0]    cfg_data_i
);
  import ibmva_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  rows_q;
  logic [CNT_W-1:0]  count;
  logic [ROW_W-1:0]  last_idx;

  logic [ACC_W-1:0]  prod_q;
  logic [ROW_W-1:0]  row_q;
  logic              add_q;
  logic              eoc_q;
  logic [ROW_W-1:0]  cnt_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic signed [OPD_W-1:0] opd_a, opd_b;
  logic signed [ACC_W-1:0] prod_d;

  logic              in_acc;
  logic              shift;
  logic              drain_done;

  cell_ctrl_t        ctrl [MAX_ROWS];
  logic [ACC_W-1:0]  cell_acc [MAX_ROWS];
  logic              cell_sat [MAX_ROWS];

  always_comb begin
    if (rows_q == '0) begin
      count = CNT_W'(1);
    end else if (rows_q > CNT_W'(MAX_ROWS)) begin
      count = CNT_W'(MAX_ROWS);
    end else begin
      count = rows_q;
    end
  end

  assign last_idx = ROW_W'(count - CNT_W'(1));

  assign opd_a  = in_data_i.matrix_value;
  assign opd_b  = in_data_i.vector_value;
  assign prod_d = ACC_W'(opd_a) * ACC_W'(opd_b);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign shift      = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);
  assign drain_done = shift && (cnt_q == last_idx);

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    assign ctrl[g].add   = (state_q == ST_ACC) && add_q && (row_q == ROW_W'(g));
    assign ctrl[g].shift = shift;
    assign ctrl[g].clear = drain_done;

    if (g == MAX_ROWS - 1) begin : g_tail
      ibmva_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl[g]),
        .prod_i    (prod_q),
        .nbr_acc_i ('0),
        .nbr_sat_i (1'b0),
        .acc_o     (cell_acc[g]),
        .sat_o     (cell_sat[g])
      );
    end else begin : g_body
      ibmva_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl[g]),
        .prod_i    (prod_q),
        .nbr_acc_i (cell_acc[g+1]),
        .nbr_sat_i (cell_sat[g+1]),
        .acc_o     (cell_acc[g]),
        .sat_o     (cell_sat[g])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prod_q <= prod_d;
      row_q  <= in_data_i.row_position;
    end
    if (shift) begin
      out_q.row_index <= cnt_q;
      out_q.sum       <= cell_acc[0];
      out_q.saturated <= cell_sat[0];
      out_q.last      <= (cnt_q == last_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= CNT_W'(1);
      add_q       <= 1'b0;
      eoc_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        rows_q <= cfg_data_i;
      end
      if (shift) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            add_q   <= in_data_i.has_product && ({1'b0, in_data_i.row_position} < count);
            eoc_q   <= in_data_i.end_of_column;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          cnt_q   <= '0;
          state_q <= eoc_q ? ST_DRAIN : ST_IDLE;
        end
        ST_DRAIN: begin
          if (drain_done) begin
            state_q <= ST_IDLE;
          end else if (shift) begin
            cnt_q <= cnt_q + ROW_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/indexed_block_matvec_accumulate_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_block_matvec_accumulate_tb
// Self-checking bench for the row-indexed Q32.32 multiply-accumulate core.
// ----------------------------------------------------------------------------
// A short table of hand-picked transactions covers operand extremes, products
// that are masked or fall outside the active row range, saturation in both
// directions and the clearing at each column end. Constrained-free random
// columns follow under several row-count settings. Every emitted row is
// compared field by field with a behavioral model of the accumulator bank or
// the table's listed values, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module indexed_block_matvec_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibmva_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned LONG_HOLD     = 150;
  localparam int unsigned STUCK_LIMIT   = 3000;
  localparam int unsigned PHASE_ITEMS   = 15;
  localparam int unsigned N_DRILLS      = 20;

  typedef struct packed {
    logic [OPD_W-1:0] mv;
    logic [OPD_W-1:0] vv;
    logic [ROW_W-1:0] row;
    logic             prod;
    logic             eoc;
    logic             known;
    logic [ACC_W-1:0] want_sum;
    logic             want_sat;
  } drill_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CNT_W-1:0]     cfg_data_i;

  logic [ACC_W-1:0]     row_acc [MAX_ROWS];
  logic                 row_sat [MAX_ROWS];
  logic [CNT_W-1:0]     rows_setting;
  out_item_t            pending_rows [$];
  out_item_t            want_row;

  bit                   tx_idle_on;
  bit                   rx_idle_on;
  bit                   hold_req;
  int unsigned          mismatches;
  int unsigned          items_in;
  int unsigned          rows_out;
  int unsigned          sat_rows;
  int unsigned          settings_written;
  int unsigned          long_holds;
  int unsigned          stuck_cycles;

  drill_t drills [N_DRILLS] = '{
    '{32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, 1'b1, 1'b1, 64'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0,  1'b1, 1'b1, 1'b1, 64'h3FFF_FFFF_0000_0001, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 4'd0,  1'b1, 1'b1, 1'b1, 64'h4000_0000_0000_0000, 1'b0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 4'd0,  1'b1, 1'b1, 1'b1, 64'hC000_0000_8000_0000, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  1'b1, 1'b1, 1'b1, 64'h1, 1'b0},
    '{32'h0001_0000, 32'h0001_0000, 4'd0,  1'b1, 1'b1, 1'b1, 64'h1_0000_0000, 1'b0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 4'd0,  1'b0, 1'b1, 1'b1, 64'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15, 1'b1, 1'b1, 1'b1, 64'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 4'd1,  1'b1, 1'b1, 1'b1, 64'h0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 4'd0,  1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 4'd0,  1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 4'd0,  1'b1, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
    '{32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, 1'b1, 1'b1, 64'h0, 1'b0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 4'd0,  1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 4'd0,  1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 4'd0,  1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0,  1'b1, 1'b1, 1'b0, 64'h0, 1'b0},
    '{32'hFFFF_8000, 32'h0002_8000, 4'd0,  1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 4'd3,  1'b0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{32'h0003_0000, 32'hFFFE_0000, 4'd0,  1'b1, 1'b1, 1'b0, 64'h0, 1'b0}
  };

  indexed_block_matvec_accumulate u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned active_row_count();
    if (rows_setting == '0) return 1;
    if (rows_setting > MAX_ROWS) return MAX_ROWS;
    return rows_setting;
  endfunction

  function automatic void clear_row_bank();
    for (int unsigned r = 0; r < MAX_ROWS; r++) begin
      row_acc[r] = '0;
      row_sat[r] = 1'b0;
    end
  endfunction

  function automatic void fold_item(input in_item_t it);
    int unsigned      n_rows;
    logic [ACC_W-1:0] prod;
    logic [ACC_W-1:0] total;
    out_item_t        r;
    n_rows = active_row_count();
    if (it.has_product && it.row_position < n_rows) begin
      prod  = {{OPD_W{it.matrix_value[OPD_W-1]}}, it.matrix_value} *
              {{OPD_W{it.vector_value[OPD_W-1]}}, it.vector_value};
      total = row_acc[it.row_position] + prod;
      if (row_acc[it.row_position][ACC_W-1] == prod[ACC_W-1] &&
          total[ACC_W-1] != prod[ACC_W-1]) begin
        total = prod[ACC_W-1] ? ACC_MIN : ACC_MAX;
        row_sat[it.row_position] = 1'b1;
      end
      row_acc[it.row_position] = total;
    end
    if (it.end_of_column) begin
      for (int unsigned i = 0; i < n_rows; i++) begin
        r.row_index = ROW_W'(i);
        r.sum       = row_acc[i];
        r.saturated = row_sat[i];
        r.last      = (i + 1 == n_rows);
        pending_rows.push_back(r);
      end
      clear_row_bank();
    end
  endfunction

  function automatic logic [OPD_W-1:0] draw_operand();
    logic [OPD_W-1:0] v;
    int unsigned      pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'hFFFF_FFFF;
        default: v = '0;
      endcase
    end else if (pick < 4) begin
      v = $urandom();
    end else begin
      v = OPD_W'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  task automatic offer_item(input in_item_t it);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_in++;
  endtask

  task automatic write_row_count(input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    rows_setting = value;
    settings_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_columns(input int unsigned budget);
    int unsigned      sent;
    int unsigned      len;
    logic [ROW_W-1:0] hot_row;
    in_item_t         it;
    sent    = 0;
    hot_row = '0;
    while (sent < budget) begin
      len = $urandom_range(0, 6);
      for (int unsigned k = 0; k <= len; k++) begin
        it.matrix_value = draw_operand();
        it.vector_value = draw_operand();
        if ($urandom_range(0, 9) == 0)
          it.row_position = ROW_W'($urandom_range(0, MAX_ROWS - 1));
        else if ($urandom_range(0, 2) == 0)
          it.row_position = hot_row;
        else
          it.row_position = ROW_W'($urandom_range(0, active_row_count() - 1));
        hot_row          = it.row_position;
        it.has_product   = (k == len) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) != 0);
        it.end_of_column = (k == len);
        offer_item(it);
        fold_item(it);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    rows_setting = CNT_W'(1);
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;
    clear_row_bank();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (drills[i]) begin
      it.matrix_value  = drills[i].mv;
      it.vector_value  = drills[i].vv;
      it.row_position  = drills[i].row;
      it.has_product   = drills[i].prod;
      it.end_of_column = drills[i].eoc;
      offer_item(it);
      fold_item(it);
      if (drills[i].known)
        pending_rows[pending_rows.size() - 1] = '{row_index: '0, sum: drills[i].want_sum,
                                                  saturated: drills[i].want_sat, last: 1'b1};
    end

    write_row_count(CNT_W'(16));
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    run_columns(PHASE_ITEMS);

    write_row_count(CNT_W'(0));
    tx_idle_on = 1'b1;
    run_columns(PHASE_ITEMS);

    write_row_count(CNT_W'(31));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_columns(PHASE_ITEMS);

    write_row_count(CNT_W'($urandom_range(2, 15)));
    tx_idle_on = 1'b1;
    run_columns(PHASE_ITEMS);

    write_row_count(CNT_W'(17));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_columns(PHASE_ITEMS);

    write_row_count(CNT_W'(1));
    tx_idle_on = 1'b1;
    run_columns(PHASE_ITEMS);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d transactions in, %0d rows out, %0d of them saturated",
             items_in, rows_out, sat_rows);
    $display("row-count settings written: %0d, long output hold-offs: %0d",
             settings_written, long_holds);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sink
    int unsigned gap;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = LONG_HOLD;
        long_holds++;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rows_out++;
      if (out_data_o.saturated) sat_rows++;
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("row %0d emitted with nothing pending", out_data_o.row_index));
      end else begin
        want_row = pending_rows.pop_front();
        if (out_data_o.row_index !== want_row.row_index)
          report_mismatch($sformatf("row_index got %0d want %0d",
                                    out_data_o.row_index, want_row.row_index));
        if (out_data_o.sum !== want_row.sum)
          report_mismatch($sformatf("row %0d sum got %h want %h",
                                    want_row.row_index, out_data_o.sum, want_row.sum));
        if (out_data_o.saturated !== want_row.saturated)
          report_mismatch($sformatf("row %0d saturated got %b want %b",
                                    want_row.row_index, out_data_o.saturated,
                                    want_row.saturated));
        if (out_data_o.last !== want_row.last)
          report_mismatch($sformatf("row %0d last got %b want %b",
                                    want_row.row_index, out_data_o.last, want_row.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
